### hw/rtl/tpd_pkg.sv
// Package for the TSPLIB point distance block: defaults, field widths,
// the metric code and the control word that travels down the pipeline.
// No dependencies.
`default_nettype none

package tpd_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int DIST_BITS         = 17;
    localparam int OUT_TDATA_BITS    = 24;

    typedef enum logic {
        METRIC_EUC_2D = 1'b0,
        METRIC_ATT    = 1'b1
    } tpd_metric_t;

    typedef struct packed {
        logic        valid;
        tpd_metric_t metric;
        logic        zero;
    } tpd_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/tpd_prep.sv
// Front end of the distance pipeline: absolute differences, squares and the
// operand handed to the root chain, in three registered stages.
// Depends on tpd_pkg.
`default_nettype none

module tpd_prep
    import tpd_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire tpd_ctrl_t                   ctrl_in,
    input  wire logic [COORD_BITS-1:0]       first_x,
    input  wire logic [COORD_BITS-1:0]       first_y,
    input  wire logic [COORD_BITS-1:0]       second_x,
    input  wire logic [COORD_BITS-1:0]       second_y,
    output tpd_ctrl_t                        ctrl_out,
    output logic      [2*COORD_BITS+2:0]     n_out
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int SW = 2 * C + 1;
    localparam int RW = 2 * C + 3;
    localparam logic [SW-1:0] LOW_MASK = (SW'(1) << (2 * FRACTION_BITS)) - SW'(1);

    logic [DW-1:0]    diff_x;
    logic [DW-1:0]    diff_y;
    logic [C-1:0]     dx_reg, dx_next;
    logic [C-1:0]     dy_reg, dy_next;
    tpd_ctrl_t        ctrl1_reg, ctrl1_next;

    logic [2*C-1:0]   sqx_reg, sqx_next;
    logic [2*C-1:0]   sqy_reg, sqy_next;
    tpd_ctrl_t        ctrl2_reg, ctrl2_next;

    logic [SW-1:0]    sum;
    logic [SW-1:0]    att_hi;
    logic             low_nz;
    logic             sum_zero;
    logic [SW-1:0]    n_att;
    logic [RW-1:0]    n_reg, n_next;
    tpd_ctrl_t        ctrl3_reg, ctrl3_next;

    always_comb begin
        diff_x     = {first_x[C-1], first_x} - {second_x[C-1], second_x};
        diff_y     = {first_y[C-1], first_y} - {second_y[C-1], second_y};
        dx_next    = diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
        dy_next    = diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
        ctrl1_next = ctrl_in;
    end

    always_comb begin
        sqx_next   = dx_reg * dx_reg;
        sqy_next   = dy_reg * dy_reg;
        ctrl2_next = ctrl1_reg;
    end

    always_comb begin
        sum      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        sum_zero = (sum == '0);
        att_hi   = sum >> (2 * FRACTION_BITS);
        low_nz   = |(sum & LOW_MASK);
        n_att    = att_hi + SW'(low_nz) - SW'(1);
        if (ctrl2_reg.metric == METRIC_ATT) begin
            n_next = sum_zero ? '0 : RW'(n_att);
        end else begin
            n_next = {sum, 2'b00};
        end
        ctrl3_next        = ctrl2_reg;
        ctrl3_next.zero   = sum_zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end else if (advance) begin
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl2_next;
            ctrl3_reg <= ctrl3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            n_reg   <= n_next;
        end
    end

    assign ctrl_out = ctrl3_reg;
    assign n_out    = n_reg;

endmodule

`default_nettype wire

### hw/rtl/tpd_root_cell.sv
// One cell of the square root chain: decides one root bit, largest t with
// K*t*t not above the operand, where K is 1 for EUC_2D and 10 for ATT.
// Depends on tpd_pkg.
`default_nettype none

module tpd_root_cell
    import tpd_pkg::*;
#(
    parameter int RW  = 2 * COORD_BITS_DEF + 3,
    parameter int RB  = COORD_BITS_DEF + 2,
    parameter int TW  = 2 * COORD_BITS_DEF + 8,
    parameter int BIT = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire tpd_ctrl_t        ctrl_in,
    input  wire logic [RW-1:0]    r_in,
    input  wire logic [RB-1:0]    t_in,
    output tpd_ctrl_t             ctrl_out,
    output logic      [RW-1:0]    r_out,
    output logic      [RB-1:0]    t_out
);

    logic [TW-1:0] term;
    logic [TW-1:0] scaled;
    logic          take;
    tpd_ctrl_t     ctrl_reg, ctrl_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RB-1:0] t_reg, t_next;

    always_comb begin
        term = (TW'(t_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        if (ctrl_in.metric == METRIC_ATT) begin
            scaled = (term << 3) + (term << 1);
        end else begin
            scaled = term;
        end
        take      = (scaled <= TW'(r_in));
        r_next    = take ? (r_in - RW'(scaled)) : r_in;
        t_next    = take ? (t_in | (RB'(1) << BIT)) : t_in;
        ctrl_next = ctrl_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            r_reg <= r_next;
            t_reg <= t_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign r_out    = r_reg;
    assign t_out    = t_reg;

endmodule

`default_nettype wire

### hw/rtl/tsplib_point_distance.sv
// Structure: three front-end stages, one root cell per root bit, one output register.
// Throughput: one beat per cycle; the whole pipeline advances together and only
// holds while the output register carries a beat that is not taken.
// Reset: synchronous, active low; clears all valid flags and selects EUC_2D.
// Top level of the TSPLIB distance block; depends on tpd_pkg, tpd_prep, tpd_root_cell.
`default_nettype none

module tsplib_point_distance
    import tpd_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic                                  cfg_wr_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // first_x, first_y, second_x, second_y from the lowest bit up
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // distance from the lowest bit up
    output logic      [OUT_TDATA_BITS-1:0]             m_tdata
);

    localparam int C  = COORD_BITS;
    localparam int RW = 2 * C + 3;
    localparam int RB = C + 2;
    localparam int TW = 2 * C + 8;
    localparam int FW = ((RB > FRACTION_BITS) ? RB : FRACTION_BITS) + 2;

    tpd_metric_t            metric_mode_reg, metric_mode_next;
    logic                   advance;
    tpd_ctrl_t              in_ctrl;
    tpd_ctrl_t              ctrl_w [RB+1];
    logic [RW-1:0]          rem_w  [RB+1];
    logic [RB-1:0]          root_w [RB+1];

    logic [RB-1:0]          root;
    logic [FW-1:0]          euc_full;
    logic [RB:0]            att_full;
    logic [DIST_BITS-1:0]   dist_sel;
    logic                   m_valid_reg, m_valid_next;
    logic [DIST_BITS-1:0]   dist_reg, dist_next;

    always_comb begin
        metric_mode_next = cfg_wr_en ? tpd_metric_t'(cfg_wr_data) : metric_mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_mode_reg <= METRIC_EUC_2D;
        end else begin
            metric_mode_reg <= metric_mode_next;
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    always_comb begin
        in_ctrl.valid  = s_tvalid;
        in_ctrl.metric = metric_mode_reg;
        in_ctrl.zero   = 1'b0;
    end

    tpd_prep #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .ctrl_in  (in_ctrl),
        .first_x  (s_tdata[0*C +: C]),
        .first_y  (s_tdata[1*C +: C]),
        .second_x (s_tdata[2*C +: C]),
        .second_y (s_tdata[3*C +: C]),
        .ctrl_out (ctrl_w[0]),
        .n_out    (rem_w[0])
    );

    assign root_w[0] = '0;

    for (genvar i = 0; i < RB; i++) begin : g_cell
        tpd_root_cell #(
            .RW  (RW),
            .RB  (RB),
            .TW  (TW),
            .BIT (RB - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .ctrl_in  (ctrl_w[i]),
            .r_in     (rem_w[i]),
            .t_in     (root_w[i]),
            .ctrl_out (ctrl_w[i+1]),
            .r_out    (rem_w[i+1]),
            .t_out    (root_w[i+1])
        );
    end

    always_comb begin
        root     = root_w[RB];
        euc_full = (FW'(root) + (FW'(1) << FRACTION_BITS)) >> (FRACTION_BITS + 1);
        att_full = ctrl_w[RB].zero ? '0 : ({1'b0, root} + (RB+1)'(1));
        if (ctrl_w[RB].metric == METRIC_ATT) begin
            dist_sel = DIST_BITS'(att_full);
        end else begin
            dist_sel = DIST_BITS'(euc_full);
        end
        m_valid_next = advance ? ctrl_w[RB].valid : m_valid_reg;
        dist_next    = (advance && ctrl_w[RB].valid) ? dist_sel : dist_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS - DIST_BITS){1'b0}}, dist_reg};

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready although the output register is empty");

    a_zero_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_w[RB].valid && ctrl_w[RB].zero) |-> (root_w[RB] == '0))
        else $error("coincident points gave a non-zero root");

    a_euc_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_w[RB].valid && ctrl_w[RB].metric == METRIC_EUC_2D)
            |-> (rem_w[RB] <= RW'({root_w[RB], 1'b0})))
        else $error("square root remainder out of range");
`endif

endmodule

`default_nettype wire

### bench/tsplib_point_distance_test.sv
// Self-checking bench for tsplib_point_distance: point pairs go in as stream beats and each
// returned distance is checked against a predictor kept in step with the metric register.
// Depends on tpd_pkg and the tsplib_point_distance RTL.
`timescale 1ns / 100ps

module tsplib_point_distance_test;
    import tpd_pkg::*;

    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int FRAC_BITS   = FRACTION_BITS_DEF;
    localparam int DATA_BITS   = ((4*COORD_BITS+7)/8)*8;
    localparam int DRAIN_WAIT  = COORD_BITS + 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint unsigned ATT_DIVISOR = 64'd10 << (2*FRAC_BITS);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t second_y;
        coord_t second_x;
        coord_t first_y;
        coord_t first_x;
    } point_pair_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic                      cfg_wr_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [DATA_BITS-1:0]      s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    logic [DIST_BITS-1:0] distance_q[$];
    tpd_metric_t          metric_seen;
    int                   fail_count;
    bit                   send_idle;
    bit                   recv_idle;
    int                   hold_cycles;

    tsplib_point_distance i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic [DIST_BITS-1:0] predict_distance(input tpd_metric_t metric,
                                                              input point_pair_t p);
        longint          ax, ay, bx, by;
        longint unsigned dx, dy, sq, quot, dist_val;
        ax = $signed(p.first_x);
        ay = $signed(p.first_y);
        bx = $signed(p.second_x);
        by = $signed(p.second_y);
        dx = (ax >= bx) ? ax - bx : bx - ax;
        dy = (ay >= by) ? ay - by : by - ay;
        sq = dx * dx + dy * dy;
        if (metric == METRIC_EUC_2D) begin
            dist_val = (floor_root(sq << 2) + (longint'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
        end else begin
            quot = sq / ATT_DIVISOR;
            if (sq % ATT_DIVISOR != 0) begin
                quot++;
            end
            dist_val = floor_root(quot);
            if (dist_val * dist_val < quot) begin
                dist_val++;
            end
        end
        return dist_val[DIST_BITS-1:0];
    endfunction

    function automatic point_pair_t make_pair(input int fx, input int fy,
                                              input int sx, input int sy);
        point_pair_t p;
        p.first_x  = fx[COORD_BITS-1:0];
        p.first_y  = fy[COORD_BITS-1:0];
        p.second_x = sx[COORD_BITS-1:0];
        p.second_y = sy[COORD_BITS-1:0];
        return p;
    endfunction

    function automatic coord_t corner_coord();
        coord_t c;
        case ($urandom_range(0, 4))
            0: c = {1'b1, {(COORD_BITS-1){1'b0}}};
            1: c = {1'b0, {(COORD_BITS-1){1'b1}}};
            2: c = '0;
            3: c = '1;
            default: c = coord_t'($urandom);
        endcase
        return c;
    endfunction

    function void report_error(input string text);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", text);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            metric_seen = METRIC_EUC_2D;
        end else begin
            if (s_tvalid && s_tready) begin
                distance_q.push_back(predict_distance(metric_seen, point_pair_t'(s_tdata)));
            end
            if (cfg_wr_en) begin
                metric_seen = tpd_metric_t'(cfg_wr_data);
            end
            if (m_tvalid && m_tready) begin
                if (distance_q.size() == 0) begin
                    report_error($sformatf("unexpected result beat, distance %0d",
                                           m_tdata[DIST_BITS-1:0]));
                end else begin
                    logic [DIST_BITS-1:0] want;
                    want = distance_q.pop_front();
                    if (m_tdata[DIST_BITS-1:0] !== want) begin
                        report_error($sformatf("distance: expected %0d, got %0d",
                                               want, m_tdata[DIST_BITS-1:0]));
                    end
                    if (m_tdata[OUT_TDATA_BITS-1:DIST_BITS] !== '0) begin
                        report_error($sformatf("tdata padding: expected 0, got 'h%0h",
                                               m_tdata[OUT_TDATA_BITS-1:DIST_BITS]));
                    end
                end
            end
        end
    end

    // The receiver may stall before each beat; a requested hold is taken in one piece.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = recv_idle ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tsplib_point_distance_test failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_pair(input point_pair_t p);
        int gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (distance_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic select_metric(input tpd_metric_t mode);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_directed();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_pair(make_pair(0, 0, 0, 0));
        send_pair(make_pair(8388607, -8388608, 8388607, -8388608));
        send_pair(make_pair(-8388608, -8388608, 8388607, 8388607));
        send_pair(make_pair(8388607, -8388608, -8388608, 8388607));
        send_pair(make_pair(0, 0, 128, 0));
        send_pair(make_pair(-200, 5, 184, 5));
        send_pair(make_pair(0, 0, 0, 127));
        send_pair(make_pair(1000, -2000, 1768, -976));
        send_pair(make_pair(-3840, 1280, 3840, -1280));
        send_pair(make_pair(0, 0, 7681, -2560));
        send_pair(make_pair(0, 0, 1, 0));
        send_pair(make_pair(-1, -1, 0, 0));
    endtask

    task automatic test_random(input int count);
        point_pair_t p;
        coord_t      ox, oy, tmp;
        int          kind, odd, t;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            p.first_x  = coord_t'($urandom);
            p.first_y  = coord_t'($urandom);
            p.second_x = coord_t'($urandom);
            p.second_y = coord_t'($urandom);
            ox = '0;
            oy = '0;
            case (kind)
                3, 4, 5: begin
                    ox = coord_t'($urandom_range(0, 1 << $urandom_range(0, 16)));
                    oy = coord_t'($urandom_range(0, 1 << $urandom_range(0, 16)));
                end
                6: begin
                    odd = 2 * $urandom_range(0, 2047) + 1;
                    ox = coord_t'(3 * 128 * odd);
                    oy = coord_t'(4 * 128 * odd);
                    if ($urandom_range(0, 1)) begin
                        oy = ox;
                        ox = coord_t'(4 * 128 * odd);
                    end
                end
                7: begin
                    t = $urandom_range(0, 2000);
                    ox = coord_t'(3 * t * 256 + $urandom_range(0, 2) - 1);
                    oy = coord_t'(t * 256 + $urandom_range(0, 2) - 1);
                end
                9: begin
                    p.first_x  = corner_coord();
                    p.first_y  = corner_coord();
                    p.second_x = corner_coord();
                    p.second_y = corner_coord();
                end
                default: ;
            endcase
            if (kind >= 3 && kind <= 8) begin
                if ($urandom_range(0, 1)) begin
                    tmp = ox;
                    ox = oy;
                    oy = tmp;
                end
                p.second_x = $urandom_range(0, 1) ? p.first_x + ox : p.first_x - ox;
                p.second_y = $urandom_range(0, 1) ? p.first_y + oy : p.first_y - oy;
            end
            send_pair(p);
        end
    endtask

    // A long receiver hold while the sender keeps offering beats back to back.
    task automatic test_backpressure();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_cycles = 300;
        for (int i = 0; i < 100; i++) begin
            send_pair(point_pair_t'({$urandom, $urandom, $urandom}));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        fail_count  = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        hold_cycles = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        select_metric(METRIC_EUC_2D);
        test_directed();
        select_metric(METRIC_ATT);
        test_directed();
        select_metric(METRIC_EUC_2D);
        test_random(250);
        select_metric(METRIC_ATT);
        test_random(250);
        test_backpressure();
        select_metric(METRIC_EUC_2D);
        test_random(250);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && distance_q.size() == 0) begin
            $display("tsplib_point_distance_test passed");
        end else begin
            $display("tsplib_point_distance_test failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_prep.sv
hw/rtl/tpd_root_cell.sv
hw/rtl/tsplib_point_distance.sv
bench/tsplib_point_distance_test.sv
